@@ src/imu_tilt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tilt_pkg: shared constants, types and functions for the tilt filter
// Holds the arctangent table, fixed formats and the CORDIC cell interface.
// ----------------------------------------------------------------------------
package imu_tilt_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    // cordic datapath: 18-bit operands shifted left by 20, plus growth
    localparam int CW               = 40;
    localparam int ZW               = 32;
    localparam int DEG_ONE          = 65536;

    localparam logic [0:0] REG_ALPHA  = 1'b0;
    localparam logic [0:0] REG_PERIOD = 1'b1;

    typedef struct packed {
        logic                 vld;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ src/imu_tilt_cordic_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tilt_cordic_cell: one vectoring CORDIC micro-rotation
// Registered stage; rotates toward y = 0 by atan(2^-STAGE).
// ----------------------------------------------------------------------------
module imu_tilt_cordic_cell
    import imu_tilt_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_cordic i_cell,
    output t_cordic      o_cell
);
    localparam logic [4:0] SIDX = 5'(STAGE);

    t_cordic r_cell, n_cell;

    // arithmetic shift is floor division
    always_comb begin
        n_cell = i_cell;
        if (i_cell.y >= 0) begin
            n_cell.x = i_cell.x + (i_cell.y >>> STAGE);
            n_cell.y = i_cell.y - (i_cell.x >>> STAGE);
            n_cell.z = i_cell.z + atan_tab(SIDX);
        end else begin
            n_cell.x = i_cell.x - (i_cell.y >>> STAGE);
            n_cell.y = i_cell.y + (i_cell.x >>> STAGE);
            n_cell.z = i_cell.z - atan_tab(SIDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= i_cell.vld;
        end
        r_cell.x <= n_cell.x;
        r_cell.y <= n_cell.y;
        r_cell.z <= n_cell.z;
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

@@ src/imu_tilt_cordic_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tilt_cordic_chain: pre-rotation plus a row of CORDIC cells
// Computes atan2(y, x) in Q16.16 degrees, one pair per cycle.
// ----------------------------------------------------------------------------
module imu_tilt_cordic_chain
    import imu_tilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_vld,
    input  wire signed [17:0]    i_y,
    input  wire signed [17:0]    i_x,
    output logic                 o_vld,
    output logic signed [ZW-1:0] o_z
);
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    t_cordic r_pre, n_pre;
    t_cordic w_link [0:STEPS];
    logic    r_zero, n_zero;
    logic    r_zq [0:STEPS];

    // quadrant fold for negative x
    always_comb begin
        logic signed [CW-1:0] xs, ys;
        xs = CW'(i_x) <<< 20;
        ys = CW'(i_y) <<< 20;
        n_zero    = (i_x == 0) && (i_y == 0);
        n_pre.vld = i_vld;
        if (xs < 0) begin
            if (ys >= 0) begin
                n_pre.x = ys;
                n_pre.y = -xs;
                n_pre.z = 32'sd5898240;
            end else begin
                n_pre.x = -ys;
                n_pre.y = xs;
                n_pre.z = -32'sd5898240;
            end
        end else begin
            n_pre.x = xs;
            n_pre.y = ys;
            n_pre.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.vld <= 1'b0;
        end else begin
            r_pre.vld <= n_pre.vld;
        end
        r_pre.x <= n_pre.x;
        r_pre.y <= n_pre.y;
        r_pre.z <= n_pre.z;
        r_zero  <= n_zero;
    end

    assign w_link[0] = r_pre;
    assign r_zq[0]   = r_zero;

    genvar g;
    generate
        for (g = 0; g < STEPS; g++) begin : g_cell
            imu_tilt_cordic_cell #(.STAGE(g)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_cell (w_link[g]),
                .o_cell (w_link[g+1])
            );
            // zero-operand flag travels beside the cells
            always_ff @(posedge i_clk) begin
                r_zq[g+1] <= r_zq[g];
            end
        end
    endgenerate

    assign o_vld = w_link[STEPS].vld;
    assign o_z   = r_zq[STEPS] ? '0 : w_link[STEPS].z;
endmodule
`default_nettype wire

@@ src/imu_tilt_complementary_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter: six-axis tilt complementary filter
// Accelerometer angles by a shared CORDIC cell row, blended with integrated gyro rates.
// ----------------------------------------------------------------------------
//   channel   direction  content
//   s_axis    in         ax, ay, az, gx, gy, gz (16-bit signed each)
//   m_axis    out        pitch, roll, yaw (1/128 degree, 16-bit signed)
//   cfg       in         index 0 blend_alpha, index 1 sample_period_us
// One sample at a time: integer square root, roll and pitch issued into the
// CORDIC cell row and a wait on it, then per axis gyro scaling (reciprocal
// multiply and one correction) and per axis blending.
// Reset clears the angle state and loads the register defaults.
// A result waits in the output register while the next sample is taken and
// worked on; that sample stalls before its output until the result has left.
module imu_tilt_complementary_filter
    import imu_tilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  wire  [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // pitch_angle, roll_angle, yaw_angle
    output logic [47:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_idx,
    input  wire  [19:0] i_cfg_data
);
    localparam int SHALF = 180 * DEG_ONE;
    localparam int SFULL = 360 * DEG_ONE;
    // rate divisor 131000000 with its factor 64 taken out against 2^16
    localparam logic [20:0] RDIV  = 21'd2046875;
    // floor(2^46 / RDIV)
    localparam logic [25:0] RECIP = 26'd34378623;
    // half the divisor, scaled down by 64 as well
    localparam logic [45:0] RBIAS = 46'd1023437;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQRT, ST_ROLL, ST_PITCH, ST_WAIT, ST_GMUL, ST_GDIV,
        ST_GEST, ST_GFIX, ST_GRND, ST_BLEND, ST_BMUL, ST_WRAP, ST_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_alpha;
    logic [19:0] r_period;
    logic signed [15:0] r_ax, r_ay, r_az;
    logic signed [15:0] r_gyro [0:2];
    logic signed [31:0] r_last [0:2];
    logic signed [31:0] r_acc [0:2];
    logic signed [31:0] r_inc [0:2];
    logic [31:0] r_rem;
    logic [16:0] r_root;
    logic [4:0]  r_cnt;
    logic [1:0]  r_ax_sel;
    logic [45:0] r_mag;
    logic [48:0] r_ph, r_pl;
    logic [24:0] r_quo;
    logic        r_neg;
    logic signed [49:0] r_sum;
    logic [47:0] r_out;
    logic        r_ovld;

    // cordic row shared by roll then pitch
    logic               w_cvld;
    logic signed [17:0] w_cy, w_cx;
    logic               w_zvld;
    logic signed [ZW-1:0] w_z;
    logic               r_zsel;

    assign w_cvld = (r_state == ST_ROLL) || (r_state == ST_PITCH);
    assign w_cy   = (r_state == ST_ROLL) ? 18'(r_ay) : -18'(r_ax);
    assign w_cx   = (r_state == ST_ROLL) ? 18'(r_az) : {1'b0, r_root};

    imu_tilt_cordic_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_cvld),
        .i_y    (w_cy),
        .i_x    (w_cx),
        .o_vld  (w_zvld),
        .o_z    (w_z)
    );

    // square root step, two bits per cycle
    logic [33:0] w_rq;
    logic [18:0] w_tst;
    logic [31:0] r_sq;
    assign w_rq  = {r_rem[31:0], r_sq[31:30]};
    assign w_tst = {r_root, 2'b01};

    // gyro rate magnitude
    logic signed [15:0] w_g;
    logic [15:0]        w_gm;
    assign w_g  = r_gyro[r_ax_sel];
    assign w_gm = w_g[15] ? 16'(-w_g) : 16'(w_g);

    // quotient estimate from the two reciprocal partial products
    logic [48:0] w_qsum;
    assign w_qsum = r_ph + (r_pl >> 23);

    // blend and wrap helpers
    logic signed [32:0] w_pred;
    logic signed [33:0] w_q;
    logic signed [33:0] w_w;
    assign w_pred = 33'(r_last[r_ax_sel]) + 33'(r_inc[r_ax_sel]);
    assign w_q    = 34'(r_sum >>> 16);

    always_comb begin
        logic signed [34:0] t;
        t = 35'(w_q) + 35'(SHALF);
        // q is within a few turns; bring into one turn by compare-subtract
        if (t >= 35'(2 * SFULL)) t = t - 35'(2 * SFULL);
        else if (t >= 35'(SFULL)) t = t - 35'(SFULL);
        else if (t < -35'(SFULL)) t = t + 35'(2 * SFULL);
        else if (t < 0) t = t + 35'(SFULL);
        w_w = 34'(t - 35'(SHALF));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_alpha  <= 16'd64225;
            r_period <= 20'd20000;
            r_last[0] <= '0;
            r_last[1] <= '0;
            r_last[2] <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ALPHA:  r_alpha  <= i_cfg_data[15:0];
                    REG_PERIOD: r_period <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovld && m_axis_tready && (r_state != ST_OUT)) r_ovld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_ax <= s_axis_tdata[15:0];
                        r_ay <= s_axis_tdata[31:16];
                        r_az <= s_axis_tdata[47:32];
                        r_gyro[0] <= s_axis_tdata[79:64];
                        r_gyro[1] <= s_axis_tdata[63:48];
                        r_gyro[2] <= s_axis_tdata[95:80];
                        r_sq   <= 32'($signed(s_axis_tdata[31:16])) *
                                  32'($signed(s_axis_tdata[31:16])) +
                                  32'($signed(s_axis_tdata[47:32])) *
                                  32'($signed(s_axis_tdata[47:32]));
                        r_rem  <= '0;
                        r_root <= '0;
                        r_cnt  <= '0;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (w_rq >= 34'(w_tst)) begin
                        r_rem  <= 32'(w_rq - 34'(w_tst));
                        r_root <= {r_root[15:0], 1'b1};
                    end else begin
                        r_rem  <= w_rq[31:0];
                        r_root <= {r_root[15:0], 1'b0};
                    end
                    r_sq  <= {r_sq[29:0], 2'b00};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) r_state <= ST_ROLL;
                end
                ST_ROLL:  begin r_state <= ST_PITCH; r_zsel <= 1'b0; end
                ST_PITCH: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (w_zvld) begin
                        if (!r_zsel) begin
                            r_acc[1] <= w_z;
                            r_zsel   <= 1'b1;
                        end else begin
                            r_acc[0] <= w_z;
                            r_acc[2] <= '0;
                            r_ax_sel <= 2'd0;
                            r_state  <= ST_GMUL;
                        end
                    end
                end
                ST_GMUL: begin
                    // |rate| * period * 1024 plus the rounding bias
                    r_mag  <= {36'(w_gm) * 36'(r_period), 10'd0} + RBIAS;
                    r_neg  <= w_g[15];
                    r_state <= ST_GDIV;
                end
                ST_GDIV: begin
                    // reciprocal multiply in two halves
                    r_ph <= 49'(r_mag[45:23]) * 49'(RECIP);
                    r_pl <= 49'(r_mag[22:0]) * 49'(RECIP);
                    r_state <= ST_GEST;
                end
                ST_GEST: begin
                    // estimate is the quotient or one below it
                    r_quo   <= 25'(w_qsum >> 23);
                    r_state <= ST_GFIX;
                end
                ST_GFIX: begin
                    r_rem   <= 32'(r_mag - 46'(r_quo) * 46'(RDIV));
                    r_state <= ST_GRND;
                end
                ST_GRND: begin
                    logic [31:0] q;
                    q = 32'(r_quo) + ((r_rem >= 32'(RDIV)) ? 32'd1 : 32'd0);
                    r_inc[r_ax_sel] <= r_neg ? -$signed(q) : $signed(q);
                    if (r_ax_sel == 2'd2) begin
                        r_ax_sel <= 2'd0;
                        r_state  <= ST_BLEND;
                    end else begin
                        r_ax_sel <= r_ax_sel + 2'd1;
                        r_state  <= ST_GMUL;
                    end
                end
                ST_BLEND: begin
                    r_sum <= 50'($signed({1'b0, r_alpha})) * 50'(w_pred);
                    r_state <= ST_BMUL;
                end
                ST_BMUL: begin
                    r_sum <= r_sum +
                             50'($signed(18'd65536 - 18'(r_alpha))) *
                             50'(r_acc[r_ax_sel]) + 50'sd32768;
                    r_state <= ST_WRAP;
                end
                ST_WRAP: begin
                    r_last[r_ax_sel] <= 32'(w_w);
                    if (r_ax_sel == 2'd2) r_state <= ST_OUT;
                    else begin
                        r_ax_sel <= r_ax_sel + 2'd1;
                        r_state  <= ST_BLEND;
                    end
                end
                ST_OUT: begin
                    if (!r_ovld || m_axis_tready) begin
                        r_out <= {16'((r_last[2] + 32'sd256) >>> 9),
                                  16'((r_last[1] + 32'sd256) >>> 9),
                                  16'((r_last[0] + 32'sd256) >>> 9)};
                        r_ovld  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;
endmodule
`default_nettype wire

@@ src/imu_tilt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tilt_checker: port-level checks for the tilt filter
// Watches handshakes and result ranges on the top level.
// ----------------------------------------------------------------------------
module imu_tilt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an accepted sample is not followed by another at once
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample accepted back to back");

    // pitch stays in range
    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd23040) &&
                          ($signed(m_axis_tdata[15:0]) >= -16'sd23040))
        else $error("pitch out of range");
endmodule

bind imu_tilt_complementary_filter imu_tilt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the six-axis tilt complementary filter
// Drives raw inertial samples and register writes, predicts the filtered
// pitch, roll and yaw in fixed point and checks every output transfer.
// ----------------------------------------------------------------------------

class tilt_scoreboard;
    logic [15:0] alpha;
    logic [19:0] period_us;
    longint      st_pitch, st_roll, st_yaw;
    logic [47:0] angle_q[$];
    int          errors;
    int          checked;

    function void clear_state();
        alpha = 16'd64225;
        period_us = 20'd20000;
        st_pitch = 0;
        st_roll = 0;
        st_yaw = 0;
        angle_q.delete();
        errors = 0;
        checked = 0;
    endfunction

    // floor shift of a signed value
    function longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function longint int_sqrt(longint n);
        longint root, b;
        root = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - root - b;
                root = (root >>> 1) + b;
            end else begin
                root = root >>> 1;
            end
            b = b >>> 2;
        end
        return root;
    endfunction

    // vectoring atan2 in Q16.16 degrees
    function longint vec_atan2(longint y, longint x);
        longint z, t, dx, dy;
        int n;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x <<< 20;
        y = y <<< 20;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end else begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        n = (imu_tilt_pkg::CORDIC_STEPS_DEF > imu_tilt_pkg::TABLE_LEN) ?
            imu_tilt_pkg::TABLE_LEN : imu_tilt_pkg::CORDIC_STEPS_DEF;
        for (int i = 0; i < n; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(imu_tilt_pkg::atan_tab(5'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(imu_tilt_pkg::atan_tab(5'(i)));
            end
        end
        return z;
    endfunction

    function longint blend_axis(longint prev, longint rate, longint acc);
        longint p, m, q, pred, sum, r;
        p = rate * longint'(period_us) * 65536;
        m = (p < 0) ? -p : p;
        q = (m + 65500000) / 131000000;
        pred = prev + ((p < 0) ? -q : q);
        sum = longint'(alpha) * pred + (65536 - longint'(alpha)) * acc + 32768;
        r = (fshr(sum, 16) + 180 * 65536) % (360 * 65536);
        if (r < 0) r += 360 * 65536;
        return r - 180 * 65536;
    endfunction

    function logic [15:0] to_angle(longint s);
        return 16'(fshr(s + 256, 9));
    endfunction

    function void note_sample(logic [95:0] d);
        longint ax, ay, az, horiz, acc_roll, acc_pitch;
        ax = longint'($signed(d[15:0]));
        ay = longint'($signed(d[31:16]));
        az = longint'($signed(d[47:32]));
        horiz = int_sqrt(ay * ay + az * az);
        acc_roll = vec_atan2(ay, az);
        acc_pitch = vec_atan2(-ax, horiz);
        st_pitch = blend_axis(st_pitch, longint'($signed(d[79:64])), acc_pitch);
        st_roll = blend_axis(st_roll, longint'($signed(d[63:48])), acc_roll);
        st_yaw = blend_axis(st_yaw, longint'($signed(d[95:80])), 0);
        angle_q.push_back({to_angle(st_yaw), to_angle(st_roll), to_angle(st_pitch)});
    endfunction

    function void check_angles(logic [47:0] got);
        logic [47:0] exp_d;
        if (angle_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected output transfer, expected none, actual %h",
                     $time, got);
            return;
        end
        exp_d = angle_q.pop_front();
        checked++;
        for (int f = 0; f < 3; f++) begin
            if (exp_d[16*f +: 16] !== got[16*f +: 16]) begin
                errors++;
                $display("%0t: angle field %0d mismatch, expected %0d, actual %0d",
                         $time, f, $signed(exp_d[16*f +: 16]),
                         $signed(got[16*f +: 16]));
            end
        end
    endfunction
endclass

module tb_top;
    import imu_tilt_pkg::*;

    localparam int LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // pitch_angle, roll_angle, yaw_angle
    logic [47:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;

    tilt_scoreboard sb;
    int  cycles;
    int  samples_sent;

    imu_tilt_complementary_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("imu_tilt_complementary_filter verification failed");
            $finish;
        end
    end

    // output side: check transfers at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_angles(m_axis_tdata);
    end

    // output side: random stall, redrawn after each transfer
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [19:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        if (idx == REG_ALPHA) sb.alpha = val[15:0];
        else sb.period_us = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // wait for all results, then the block's latency
    task automatic drain();
        while (sb.angle_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [95:0] d);
        int gap;
        gap = $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0 && $urandom_range(0, 3) != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(d);
        samples_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [15:0] rand_field(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 4000)) - 2000);
            default: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    initial begin
        logic [95:0] d;
        logic [15:0] f [6];
        int mode;
        sb = new();
        sb.clear_state();
        cycles = 0;
        samples_sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_ALPHA;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, zero vectors, negative z, three roll quadrants
        send_sample('0);
        send_sample({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        send_sample({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_sample({48'h0, 16'h8000, 16'h0, 16'h0});
        send_sample({48'h0, 16'h8000, 16'h4000, 16'h0});
        send_sample({48'h0, 16'h8000, 16'hc000, 16'h7fff});
        send_sample({48'h0, 16'h0, 16'h0, 16'h8000});
        send_sample({48'h0, 16'h4000, 16'h0, 16'h0});
        send_sample({16'h7fff, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h4000});
        drain();
        // alpha zero: accelerometer only
        write_reg(REG_ALPHA, 20'd0);
        send_sample({48'h1234, 16'h4000, 16'hc000, 16'h2000});
        send_sample({48'h0, 16'hc000, 16'h4000, 16'he000});
        drain();
        // maximum alpha, maximum and zero period
        write_reg(REG_ALPHA, 20'hffff);
        write_reg(REG_PERIOD, 20'hfffff);
        for (int k = 0; k < 6; k++)
            send_sample({16'h7fff, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h4000});
        drain();
        write_reg(REG_PERIOD, 20'd0);
        send_sample({16'h7fff, 16'h7fff, 16'h7fff, 16'h100, 16'h4000, 16'h0});
        drain();

        // random phases with several settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(REG_ALPHA, 20'd64225); write_reg(REG_PERIOD, 20'd20000); end
                1: begin write_reg(REG_ALPHA, 20'd1); write_reg(REG_PERIOD, 20'd1); end
                2: begin
                    write_reg(REG_ALPHA, 20'($urandom_range(0, 65535)));
                    write_reg(REG_PERIOD, 20'($urandom_range(1, 1000000)));
                end
                3: begin write_reg(REG_ALPHA, 20'hffff); write_reg(REG_PERIOD, 20'd1000000); end
                default: begin
                    write_reg(REG_ALPHA, 20'($urandom_range(0, 65535)));
                    write_reg(REG_PERIOD, 20'($urandom));
                end
            endcase
            for (int n = 0; n < 105; n++) begin
                mode = $urandom_range(0, 9);
                for (int k = 0; k < 6; k++)
                    f[k] = rand_field(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
                d = {f[5], f[4], f[3], f[2], f[1], f[0]};
                send_sample(d);
            end
            // sender waits for every pending result
            drain();
        end

        drain();
        $display("run covered %0d samples, %0d results checked, across 8 register settings",
                 samples_sent, sb.checked);
        if (sb.errors == 0 && sb.angle_q.size() == 0) begin
            $display("imu_tilt_complementary_filter verification clean");
        end else begin
            $display("imu_tilt_complementary_filter verification failed");
        end
        $finish;
    end
endmodule
